// ----- hw/rtl/lpfd_pkg.sv -----
// Shared types and constants for the length-prefixed frame deframer.
`timescale 1ns / 1ps
package lpfd_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 65536;
	localparam int unsigned HDR_BYTES       = 16;
	localparam int unsigned LIMIT_W         = 17;
	localparam int unsigned CFG_DATA_W      = 17;

	localparam logic [LIMIT_W-1:0] PAYLOAD_LIMIT_RST    = 17'd65536;
	localparam logic [7:0]         EXPECTED_VERSION_RST = 8'd1;

	// Header magic "P4BU"
	localparam logic [7:0] MAGIC0 = 8'h50;
	localparam logic [7:0] MAGIC1 = 8'h34;
	localparam logic [7:0] MAGIC2 = 8'h42;
	localparam logic [7:0] MAGIC3 = 8'h55;

	typedef enum logic [0:0] {
		REG_PAYLOAD_LIMIT    = 1'b0,
		REG_EXPECTED_VERSION = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EV_PAYLOAD  = 2'd0,
		EV_EMPTY    = 2'd1,
		EV_BAD_HDR  = 2'd2,
		EV_OVERSIZE = 2'd3
	} event_t;

	typedef struct packed {
		logic        bad;
		logic [7:0]  kind;
		logic [31:0] seq;
		logic [31:0] len;
	} hdr_info_t;

	typedef struct packed {
		event_t      ev;
		logic [7:0]  kind;
		logic [31:0] seq;
		logic [31:0] len;
		logic [15:0] offset;
		logic [7:0]  data;
		logic        last;
	} res_t;

endpackage

// ----- hw/rtl/lpfd_hdr_collect.sv -----
// Header byte shift line and header field decode.
`timescale 1ns / 1ps
module lpfd_hdr_collect
	import lpfd_pkg::*;
(
	input  logic            clk,
	input  logic            shift_en,
	input  logic [7:0]      cur_byte,
	input  logic [7:0]      expected_version,
	output hdr_info_t       info
);

	// Holds header bytes 0..14; the current beat supplies byte 15.
	logic [7:0] hdr_q [HDR_BYTES-1];

	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < HDR_BYTES - 2; i++) begin
				hdr_q[i] <= hdr_q[i+1];
			end
			hdr_q[HDR_BYTES-2] <= cur_byte;
		end
	end

	always_comb begin
		info.bad  = (hdr_q[0] != MAGIC0) || (hdr_q[1] != MAGIC1) ||
		            (hdr_q[2] != MAGIC2) || (hdr_q[3] != MAGIC3) ||
		            (hdr_q[4] != expected_version);
		info.kind = hdr_q[5];
		info.seq  = {hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]};
		info.len  = {cur_byte, hdr_q[14], hdr_q[13], hdr_q[12]};
	end

endmodule

// ----- hw/rtl/lpfd_frame_ctrl.sv -----
// Frame state: header count, payload tracking and result formation.
`timescale 1ns / 1ps
module lpfd_frame_ctrl
	import lpfd_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         cur_byte,
	input  logic [LIMIT_W-1:0] payload_limit,
	input  hdr_info_t          info,
	output logic               shift_en,
	output logic               res_valid,
	output res_t               res
);

	localparam int unsigned LW    = $clog2(MAX_PAYLOAD + 1);
	localparam logic [31:0] MAX_W = 32'(MAX_PAYLOAD);
	localparam logic [3:0]  HLAST = 4'(HDR_BYTES - 1);

	logic [3:0]    hcnt_q;
	logic          in_payload_q;
	logic [LW-1:0] len_held_q;
	logic [LW-1:0] count_q;
	logic [7:0]    kind_held_q;
	logic [31:0]   seq_held_q;

	logic [LW:0]   cnt_inc;
	logic          fin;
	logic [31:0]   cnt32;
	logic [31:0]   lim32;
	logic          hdr_done;
	logic          oversize;
	logic          empty;

	always_comb begin
		cnt_inc  = {1'b0, count_q} + (LW+1)'(1);
		fin      = cnt_inc >= {1'b0, len_held_q};
		cnt32    = 32'(count_q);
		lim32    = (32'(payload_limit) > MAX_W) ? MAX_W : 32'(payload_limit);
		hdr_done = !in_payload_q && (hcnt_q == HLAST);
		oversize = info.len > lim32;
		empty    = info.len == 32'd0;
		shift_en = step && !in_payload_q;

		res_valid  = in_payload_q || hdr_done;
		res.ev     = EV_PAYLOAD;
		res.kind   = kind_held_q;
		res.seq    = seq_held_q;
		res.len    = 32'(len_held_q);
		res.offset = cnt32[15:0];
		res.data   = cur_byte;
		res.last   = fin;
		if (!in_payload_q) begin
			res.offset = '0;
			res.data   = '0;
			res.last   = 1'b1;
			res.kind   = info.kind;
			res.seq    = info.seq;
			res.len    = info.len;
			if (info.bad) begin
				res.ev   = EV_BAD_HDR;
				res.kind = '0;
				res.seq  = '0;
				res.len  = '0;
			end else if (oversize) begin
				res.ev = EV_OVERSIZE;
			end else if (empty) begin
				res.ev = EV_EMPTY;
			end else begin
				res_valid = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q       <= '0;
			in_payload_q <= 1'b0;
			len_held_q   <= '0;
			count_q      <= '0;
			kind_held_q  <= '0;
			seq_held_q   <= '0;
		end else if (step) begin
			if (in_payload_q) begin
				if (fin) begin
					in_payload_q <= 1'b0;
					len_held_q   <= '0;
					count_q      <= '0;
					kind_held_q  <= '0;
					seq_held_q   <= '0;
				end else begin
					count_q <= cnt_inc[LW-1:0];
				end
			end else if (!hdr_done) begin
				hcnt_q <= hcnt_q + 4'd1;
			end else begin
				hcnt_q <= '0;
				if (!info.bad && !oversize && !empty) begin
					// len <= limit <= MAX_PAYLOAD, so it fits the held width
					in_payload_q <= 1'b1;
					len_held_q   <= info.len[LW-1:0];
					count_q      <= '0;
					kind_held_q  <= info.kind;
					seq_held_q   <= info.seq;
				end
			end
		end
	end

	a_hcnt_idle_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> hcnt_q == 4'd0)
		else $error("header count moved during payload");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (count_q < len_held_q))
		else $error("payload count reached frame length");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid && res.last) |=> !in_payload_q)
		else $error("frame end did not return to header collection");

	a_payload_only_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.ev == EV_PAYLOAD) |-> in_payload_q)
		else $error("payload beat outside a frame");

endmodule

// ----- hw/rtl/length_prefixed_frame_deframer_top.sv -----
// Top level of the length-prefixed frame deframer.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | sink      | in_valid / in_ready  | rx_byte
//  out     | source    | out_valid / out_ready| event_res, frame_kind, frame_seq,
//          |           |                      | frame_len, byte_offset, data_byte, last
//  cfg     | sink      | cfg_we               | cfg_idx, cfg_wdata
//
// One byte per cycle, sustained while out_ready does not hold the output. A beat is registered in
// the input register, and its result, if any, is then registered in the output register.
// Header check and length compare sit between those two registers.
// Reset clears all control state and loads payload_limit = 65536, expected_version = 1.
// out_ready low holds the output register; the input register still takes a beat
// while the output register is empty or draining.
`timescale 1ns / 1ps
module length_prefixed_frame_deframer_top
	import lpfd_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            event_res,
	output logic [7:0]            frame_kind,
	output logic [31:0]           frame_seq,
	output logic [31:0]           frame_len,
	output logic [15:0]           byte_offset,
	output logic [7:0]            data_byte,
	output logic                  last,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [LIMIT_W-1:0] payload_limit_q;
	logic [7:0]         expected_version_q;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       v_s2;
	res_t       res_s2;

	logic       s2_free;
	logic       step;
	logic       shift_en;
	logic       res_valid;
	res_t       res;
	hdr_info_t  info;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_limit_q    <= PAYLOAD_LIMIT_RST;
			expected_version_q <= EXPECTED_VERSION_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_PAYLOAD_LIMIT:    payload_limit_q    <= cfg_wdata[LIMIT_W-1:0];
				REG_EXPECTED_VERSION: expected_version_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign s2_free  = !v_s2 || out_ready;
	assign in_ready = !v_s1 || s2_free;
	assign step     = v_s1 && s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (s2_free) begin
				v_s2 <= step && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			byte_s1 <= rx_byte;
		end
		if (s2_free) begin
			res_s2 <= res;
		end
	end

	lpfd_hdr_collect u_hdr (
		.clk              (clk),
		.shift_en         (shift_en),
		.cur_byte         (byte_s1),
		.expected_version (expected_version_q),
		.info             (info)
	);

	lpfd_frame_ctrl #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.cur_byte      (byte_s1),
		.payload_limit (payload_limit_q),
		.info          (info),
		.shift_en      (shift_en),
		.res_valid     (res_valid),
		.res           (res)
	);

	assign out_valid   = v_s2;
	assign event_res   = res_s2.ev;
	assign frame_kind  = res_s2.kind;
	assign frame_seq   = res_s2.seq;
	assign frame_len   = res_s2.len;
	assign byte_offset = res_s2.offset;
	assign data_byte   = res_s2.data;
	assign last        = res_s2.last;

endmodule
